### hw/rtl/arp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;
  localparam int TAG_W = 16;
  localparam int AGE_W = 17;
  localparam int ELAPSED_W = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [MAC_W-1:0] BCAST_MAC = '1;

  // Event codes.
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_RECV = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_FRAME   = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_IP   = 2'd1;
  localparam logic [1:0] REG_HOLDOFF  = 2'd2;
  localparam logic [1:0] REG_LIFETIME = 2'd3;

  localparam logic [AGE_W-1:0] HOLDOFF_RESET  = 17'd5000;
  localparam logic [AGE_W-1:0] LIFETIME_RESET = 17'd30000;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } map_entry_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [AGE_W-1:0] age;
  } req_entry_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [IP_W-1:0]  ip;
  } pend_entry_t;

  function automatic logic [AGE_W-1:0] age_add(input logic [AGE_W-1:0] a,
                                               input logic [ELAPSED_W-1:0] b);
    logic [AGE_W:0] s;
    s = {1'b0, a} + {2'b00, b};
    return s[AGE_W] ? AGE_MAX : s[AGE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/arp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module arp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/arp_resolver_with_pending_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ARP resolver with a queue of datagrams waiting for address resolution.
// Input channel (in_valid / in_stall) carries one event per request: a send,
// a received frame or a tick. Output channel (out_valid / out_stall) carries
// the results, and last marks the final result of an event; ticks, ignored
// frames and silent sends give none. The four registers sit on an APB-style
// port at byte addresses 0, 8, 16 and 24; the user must write them only while
// idle, as the block itself does not enforce it. The cache, the request
// table and the pending queue each live in a single-port-read RAM with a
// registered read; every event is a sequence of scans over those RAMs, one
// entry per cycle, so the block takes one event at a time and holds in_stall
// high while it works. An ARP frame then works through the pending queue, and
// each queued next hop is looked up by a full scan of the cache. The last
// result is held back in a holding register so that its last flag is known,
// then moved to an output register; a stalled receiver simply parks the
// sequencer in its current step with nothing lost.
// Reset clears the valid bits of the cache and request table and empties the
// queue at once; the RAM contents need no clearing pass.
module arp_resolver_with_pending_queue #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int REQUEST_ENTRIES = 8,
  parameter int PENDING_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  // event input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] hop_addr,
  input  wire logic [15:0] datagram_tag,
  input  wire logic [47:0] frame_dst_mac,
  input  wire logic [15:0] frame_type,
  input  wire logic        frame_parse_ok,
  input  wire logic [15:0] arp_opcode,
  input  wire logic [31:0] arp_sender_ip,
  input  wire logic [47:0] arp_sender_mac,
  input  wire logic [31:0] arp_tpa,
  input  wire logic [15:0] elapsed_ms,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [47:0]      dest_mac,
  output logic [31:0]      out_ip,
  output logic [15:0]      out_tag,
  output logic             last
);

  import arp_pkg::*;

  localparam int CIW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int RIW  = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int PIW  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int PCW  = $clog2(PENDING_ENTRIES + 1);
  localparam int MAXN = (CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES : REQUEST_ENTRIES;
  localparam int SW   = $clog2(MAXN + 1);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_SEND_MAP  = 5'd1;
  localparam logic [4:0] S_SEND_HIT  = 5'd2;
  localparam logic [4:0] S_SEND_REQ  = 5'd3;
  localparam logic [4:0] S_SEND_UPD  = 5'd4;
  localparam logic [4:0] S_SEND_DROP = 5'd5;
  localparam logic [4:0] S_SEND_BC   = 5'd6;
  localparam logic [4:0] S_RX        = 5'd7;
  localparam logic [4:0] S_LEARN_MAP = 5'd8;
  localparam logic [4:0] S_LEARN_WR  = 5'd9;
  localparam logic [4:0] S_LEARN_REQ = 5'd10;
  localparam logic [4:0] S_REPLY     = 5'd11;
  localparam logic [4:0] S_PEND      = 5'd12;
  localparam logic [4:0] S_PEND_RD   = 5'd13;
  localparam logic [4:0] S_PEND_LD   = 5'd14;
  localparam logic [4:0] S_PEND_MAP  = 5'd15;
  localparam logic [4:0] S_PEND_ACT  = 5'd16;
  localparam logic [4:0] S_TICK_REQ  = 5'd17;
  localparam logic [4:0] S_TICK_MAP  = 5'd18;
  localparam logic [4:0] S_FIN       = 5'd19;

  // Configuration registers.
  logic [MAC_W-1:0] own_mac;
  logic [IP_W-1:0]  own_ip;
  logic [AGE_W-1:0] holdoff;
  logic [AGE_W-1:0] lifetime;

  // The event being worked on.
  logic [IP_W-1:0]      item_hop;
  logic [TAG_W-1:0]     item_tag;
  logic [MAC_W-1:0]     item_dst;
  logic [15:0]          item_type;
  logic                 item_ok;
  logic [15:0]          item_op;
  logic [IP_W-1:0]      item_sip;
  logic [MAC_W-1:0]     item_smac;
  logic [IP_W-1:0]      item_tip;
  logic [ELAPSED_W-1:0] item_elapsed;

  logic [4:0] state;

  // Scan machinery shared by every RAM sweep.
  logic [SW-1:0] scan_cnt;
  logic          rd_v;
  logic [SW-1:0] rd_idx;
  logic [SW-1:0] scan_n;
  logic          is_cscan;
  logic          is_rscan;
  logic          scan_done;
  logic [CIW-1:0] ci;
  logic [RIW-1:0] ri;

  // Scan results.
  logic             f_hit;
  logic [CIW-1:0]   f_idx;
  logic [MAC_W-1:0] f_mac;
  logic [CIW-1:0]   old_c_idx;
  logic [AGE_W-1:0] old_c_age;
  logic             r_hit;
  logic [RIW-1:0]   r_idx;
  logic [AGE_W-1:0] r_age;
  logic [RIW-1:0]   old_r_idx;
  logic [AGE_W-1:0] old_r_age;
  logic             bc;
  logic             drop;

  // Valid bits and queue pointers.
  logic [CACHE_ENTRIES-1:0]   map_valid;
  logic [REQUEST_ENTRIES-1:0] req_valid;
  logic [PCW-1:0]             pend_count;
  logic [PCW-1:0]             k;
  logic [PCW-1:0]             w;
  logic [TAG_W-1:0]           p_tag;
  logic [IP_W-1:0]            p_ip;

  // RAM ports.
  logic        map_we;
  logic [CIW-1:0] map_waddr;
  map_entry_t  map_wdata;
  map_entry_t  map_rdata;
  logic        req_we;
  logic [RIW-1:0] req_waddr;
  req_entry_t  req_wdata;
  req_entry_t  req_rdata;
  logic        pend_we;
  logic [PIW-1:0] pend_waddr;
  pend_entry_t pend_wdata;
  pend_entry_t pend_rdata;

  logic [IP_W-1:0] c_key;
  logic            c_match;
  logic            r_match;
  logic [AGE_W-1:0] c_new_age;
  logic [AGE_W-1:0] r_new_age;

  logic            map_any_free;
  logic [CIW-1:0]  map_free_idx;
  logic            req_any_free;
  logic [RIW-1:0]  req_free_idx;
  logic [CIW-1:0]  learn_slot;
  logic [RIW-1:0]  req_slot;
  logic            bc_now;
  logic            dst_ok;
  logic            ipv4_ok;
  logic            arp_ok;
  logic            reply_due;

  // Result staging: one held result, then the output register.
  logic             hold_v;
  logic [2:0]       hold_kind;
  logic [MAC_W-1:0] hold_mac;
  logic [IP_W-1:0]  hold_ip;
  logic [TAG_W-1:0] hold_tag;
  logic             emit_en;
  logic [2:0]       emit_kind;
  logic [MAC_W-1:0] emit_mac;
  logic [IP_W-1:0]  emit_ip;
  logic [TAG_W-1:0] emit_tag;
  logic             flush_en;
  logic             out_free;
  logic             fire_emit;
  logic             fire_flush;
  logic             accept;
  logic             cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac  <= '0;
      own_ip   <= '0;
      holdoff  <= HOLDOFF_RESET;
      lifetime <= LIFETIME_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_OWN_MAC:  own_mac  <= pwdata[MAC_W-1:0];
        REG_OWN_IP:   own_ip   <= pwdata[IP_W-1:0];
        REG_HOLDOFF:  holdoff  <= pwdata[AGE_W-1:0];
        REG_LIFETIME: lifetime <= pwdata[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_OWN_MAC:  prdata = {16'd0, own_mac};
      REG_OWN_IP:   prdata = {32'd0, own_ip};
      REG_HOLDOFF:  prdata = {47'd0, holdoff};
      REG_LIFETIME: prdata = {47'd0, lifetime};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------
  arp_ram #(.WIDTH($bits(map_entry_t)), .DEPTH(CACHE_ENTRIES)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (scan_cnt[CIW-1:0]),
    .rdata (map_rdata)
  );

  arp_ram #(.WIDTH($bits(req_entry_t)), .DEPTH(REQUEST_ENTRIES)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_waddr),
    .wdata (req_wdata),
    .raddr (scan_cnt[RIW-1:0]),
    .rdata (req_rdata)
  );

  arp_ram #(.WIDTH($bits(pend_entry_t)), .DEPTH(PENDING_ENTRIES)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (k[PIW-1:0]),
    .rdata (pend_rdata)
  );

  // ---------------------------------------------------------------------
  // Decode of the current step
  // ---------------------------------------------------------------------
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign is_cscan = (state == S_SEND_MAP) || (state == S_LEARN_MAP) ||
                    (state == S_PEND_MAP) || (state == S_TICK_MAP);
  assign is_rscan = (state == S_SEND_REQ) || (state == S_LEARN_REQ) ||
                    (state == S_TICK_REQ);
  assign scan_n    = is_rscan ? SW'(REQUEST_ENTRIES) : SW'(CACHE_ENTRIES);
  assign scan_done = (scan_cnt == scan_n) && !rd_v;
  assign ci = rd_idx[CIW-1:0];
  assign ri = rd_idx[RIW-1:0];

  always_comb begin
    unique case (state)
      S_LEARN_MAP: c_key = item_sip;
      S_PEND_MAP:  c_key = p_ip;
      default:     c_key = item_hop;
    endcase
  end

  assign c_match   = map_valid[ci] && (map_rdata.ip == c_key);
  assign r_match   = req_valid[ri] &&
                     (req_rdata.ip == ((state == S_SEND_REQ) ? item_hop : item_sip));
  assign c_new_age = age_add(map_rdata.age, item_elapsed);
  assign r_new_age = age_add(req_rdata.age, item_elapsed);

  // First free slot of each table, lowest index first.
  always_comb begin
    map_any_free = 1'b0;
    map_free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!map_valid[i]) begin
        map_any_free = 1'b1;
        map_free_idx = CIW'(i);
      end
    end
  end

  always_comb begin
    req_any_free = 1'b0;
    req_free_idx = '0;
    for (int i = REQUEST_ENTRIES - 1; i >= 0; i--) begin
      if (!req_valid[i]) begin
        req_any_free = 1'b1;
        req_free_idx = RIW'(i);
      end
    end
  end

  assign learn_slot = f_hit ? f_idx : (map_any_free ? map_free_idx : old_c_idx);
  assign req_slot   = req_any_free ? req_free_idx : old_r_idx;
  assign bc_now     = r_hit ? (r_age > holdoff) : 1'b1;
  assign dst_ok     = (item_dst == own_mac) || (item_dst == BCAST_MAC);
  assign ipv4_ok    = (item_type == ETYPE_IPV4) && item_ok;
  assign arp_ok     = (item_type == ETYPE_ARP) && item_ok;
  assign reply_due  = (item_op == ARP_OP_REQUEST) && (item_tip == own_ip);

  // RAM writes.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = ci;
    map_wdata = '{ip: map_rdata.ip, mac: map_rdata.mac, age: c_new_age};
    if (state == S_LEARN_WR) begin
      map_we    = 1'b1;
      map_waddr = learn_slot;
      map_wdata = '{ip: item_sip, mac: item_smac, age: '0};
    end else if (state == S_TICK_MAP) begin
      map_we = rd_v && map_valid[ci];
    end
  end

  always_comb begin
    req_we    = 1'b0;
    req_waddr = ri;
    req_wdata = '{ip: req_rdata.ip, age: r_new_age};
    if (state == S_SEND_UPD) begin
      req_we    = bc_now;
      req_waddr = r_hit ? r_idx : req_slot;
      req_wdata = '{ip: item_hop, age: '0};
    end else if (state == S_TICK_REQ) begin
      req_we = rd_v && req_valid[ri];
    end
  end

  always_comb begin
    pend_we    = 1'b0;
    pend_waddr = w[PIW-1:0];
    pend_wdata = '{tag: p_tag, ip: p_ip};
    if (state == S_SEND_UPD) begin
      pend_we    = pend_count < PCW'(PENDING_ENTRIES);
      pend_waddr = pend_count[PIW-1:0];
      pend_wdata = '{tag: item_tag, ip: item_hop};
    end else if (state == S_PEND_ACT) begin
      pend_we = !f_hit;
    end
  end

  // Results produced by each step.
  always_comb begin
    emit_en   = 1'b0;
    emit_kind = KIND_FRAME;
    emit_mac  = f_mac;
    emit_ip   = item_hop;
    emit_tag  = item_tag;
    unique case (state)
      S_SEND_HIT: emit_en = 1'b1;
      S_SEND_DROP: begin
        emit_en   = drop;
        emit_kind = KIND_DROP;
        emit_mac  = '0;
      end
      S_SEND_BC: begin
        emit_en   = bc;
        emit_kind = KIND_REQUEST;
        emit_mac  = BCAST_MAC;
        emit_tag  = '0;
      end
      S_RX: begin
        emit_en   = dst_ok && ipv4_ok;
        emit_kind = KIND_DELIVER;
        emit_mac  = '0;
        emit_ip   = '0;
      end
      S_REPLY: begin
        emit_en   = reply_due;
        emit_kind = KIND_REPLY;
        emit_mac  = item_smac;
        emit_ip   = item_sip;
        emit_tag  = '0;
      end
      S_PEND_ACT: begin
        emit_en = f_hit;
        emit_ip = p_ip;
        emit_tag = p_tag;
      end
      default: ;
    endcase
  end

  assign flush_en   = (state == S_FIN);
  assign out_free   = !out_valid || !out_stall;
  assign fire_emit  = emit_en && (!hold_v || out_free);
  assign fire_flush = flush_en && (!hold_v || out_free);

  // ---------------------------------------------------------------------
  // Held result and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (hold_v && (fire_emit || fire_flush)) begin
        out_valid <= 1'b1;
        out_kind  <= hold_kind;
        dest_mac  <= hold_mac;
        out_ip    <= hold_ip;
        out_tag   <= hold_tag;
        last      <= fire_flush;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire_emit) begin
        hold_v    <= 1'b1;
        hold_kind <= emit_kind;
        hold_mac  <= emit_mac;
        hold_ip   <= emit_ip;
        hold_tag  <= emit_tag;
      end else if (fire_flush) begin
        hold_v <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Event capture
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      item_hop     <= hop_addr;
      item_tag     <= datagram_tag;
      item_dst     <= frame_dst_mac;
      item_type    <= frame_type;
      item_ok      <= frame_parse_ok;
      item_op      <= arp_opcode;
      item_sip     <= arp_sender_ip;
      item_smac    <= arp_sender_mac;
      item_tip     <= arp_tpa;
      item_elapsed <= elapsed_ms;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_cnt   <= '0;
      rd_v       <= 1'b0;
      map_valid  <= '0;
      req_valid  <= '0;
      pend_count <= '0;
      f_hit      <= 1'b0;
      r_hit      <= 1'b0;
    end else begin
      // Sweep one entry per cycle; the data of the previous address is seen now.
      if (is_cscan || is_rscan) begin
        if (scan_cnt < scan_n) begin
          scan_cnt <= scan_cnt + SW'(1);
        end
        rd_v   <= scan_cnt < scan_n;
        rd_idx <= scan_cnt;
        if (scan_cnt == '0 && !rd_v) begin
          f_hit <= 1'b0;
          r_hit <= 1'b0;
        end
        if (scan_done) begin
          scan_cnt <= '0;
        end
      end

      if (is_cscan && rd_v) begin
        if (c_match && !f_hit) begin
          f_hit <= 1'b1;
          f_idx <= ci;
          f_mac <= map_rdata.mac;
        end
        if (rd_idx == '0 || map_rdata.age > old_c_age) begin
          old_c_idx <= ci;
          old_c_age <= map_rdata.age;
        end
        if (state == S_TICK_MAP && map_valid[ci] && c_new_age > lifetime) begin
          map_valid[ci] <= 1'b0;
        end
      end

      if (is_rscan && rd_v) begin
        if (r_match && !r_hit) begin
          r_hit <= 1'b1;
          r_idx <= ri;
          r_age <= req_rdata.age;
        end
        if (rd_idx == '0 || req_rdata.age > old_r_age) begin
          old_r_idx <= ri;
          old_r_age <= req_rdata.age;
        end
        if (state == S_LEARN_REQ && r_match) begin
          req_valid[ri] <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_SEND: state <= S_SEND_MAP;
              FUNC_RECV: state <= S_RX;
              FUNC_TICK: state <= S_TICK_REQ;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_SEND_MAP: begin
          if (scan_done) begin
            state <= f_hit ? S_SEND_HIT : S_SEND_REQ;
          end
        end
        S_SEND_HIT: begin
          if (fire_emit) begin
            state <= S_FIN;
          end
        end
        S_SEND_REQ: begin
          if (scan_done) begin
            state <= S_SEND_UPD;
          end
        end
        S_SEND_UPD: begin
          bc   <= bc_now;
          drop <= pend_count >= PCW'(PENDING_ENTRIES);
          if (!r_hit) begin
            req_valid[req_slot] <= 1'b1;
          end
          if (pend_count < PCW'(PENDING_ENTRIES)) begin
            pend_count <= pend_count + PCW'(1);
          end
          state <= S_SEND_DROP;
        end
        S_SEND_DROP: begin
          if (!drop || fire_emit) begin
            state <= S_SEND_BC;
          end
        end
        S_SEND_BC: begin
          if (!bc || fire_emit) begin
            state <= S_FIN;
          end
        end
        S_RX: begin
          if (!dst_ok) begin
            state <= S_FIN;
          end else if (ipv4_ok) begin
            if (fire_emit) begin
              state <= S_FIN;
            end
          end else if (arp_ok) begin
            if (item_op == ARP_OP_REQUEST || item_op == ARP_OP_REPLY) begin
              state <= S_LEARN_MAP;
            end else begin
              k     <= '0;
              w     <= '0;
              state <= S_PEND;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_LEARN_MAP: begin
          if (scan_done) begin
            state <= S_LEARN_WR;
          end
        end
        S_LEARN_WR: begin
          map_valid[learn_slot] <= 1'b1;
          state <= S_LEARN_REQ;
        end
        S_LEARN_REQ: begin
          if (scan_done) begin
            state <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (!reply_due || fire_emit) begin
            k     <= '0;
            w     <= '0;
            state <= S_PEND;
          end
        end
        S_PEND: begin
          if (k < pend_count) begin
            state <= S_PEND_RD;
          end else begin
            pend_count <= w;
            state      <= S_FIN;
          end
        end
        S_PEND_RD: state <= S_PEND_LD;
        S_PEND_LD: begin
          p_tag <= pend_rdata.tag;
          p_ip  <= pend_rdata.ip;
          state <= S_PEND_MAP;
        end
        S_PEND_MAP: begin
          if (scan_done) begin
            state <= S_PEND_ACT;
          end
        end
        S_PEND_ACT: begin
          if (!f_hit) begin
            w     <= w + PCW'(1);
            k     <= k + PCW'(1);
            state <= S_PEND;
          end else if (fire_emit) begin
            k     <= k + PCW'(1);
            state <= S_PEND;
          end
        end
        S_TICK_REQ: begin
          if (scan_done) begin
            state <= S_TICK_MAP;
          end
        end
        S_TICK_MAP: begin
          if (scan_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fire_flush) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_v)
    else $error("result still held while idle");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= PCW'(PENDING_ENTRIES))
    else $error("pending queue count beyond its depth");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (rd_idx < scan_n))
    else $error("scan read index beyond the table");

  a_compact: assert property (@(posedge clk) disable iff (rst)
    (state == S_PEND_ACT) |-> (w <= k && k < pend_count))
    else $error("queue compaction pointers out of order");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the ARP resolver with its pending queue.
// An initial block fills a queue of events phase by phase. A clocked driver
// presents them on the input channel, and a clocked monitor checks every result
// against an internal model of the cache, the request table and the queue.
module tb;
  import arp_pkg::*;

  // One event as presented on the input channel.
  typedef struct {
    logic [1:0]  func;
    logic [31:0] hop;
    logic [15:0] tag;
    logic [47:0] dst;
    logic [15:0] ftype;
    logic        pok;
    logic [15:0] op;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [31:0] tip;
    logic [15:0] elapsed;
  } arp_event_t;

  // One result as it should appear on the output channel.
  typedef struct {
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] tag;
    logic        fin;
  } arp_result_t;

  localparam int N_CACHE = 16;
  localparam int N_REQ   = 8;
  localparam int N_PEND  = 16;
  // Quiet time before a register write and at the end. An ARP frame that
  // flushes a full queue is the slowest event.
  localparam int SETTLE_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_stall;
  arp_event_t  cur_ev;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [47:0] dest_mac;
  logic [31:0] out_ip;
  logic [15:0] out_tag;
  logic        last;

  always #5 clk = ~clk;

  arp_resolver_with_pending_queue dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(cur_ev.func), .hop_addr(cur_ev.hop), .datagram_tag(cur_ev.tag),
    .frame_dst_mac(cur_ev.dst), .frame_type(cur_ev.ftype),
    .frame_parse_ok(cur_ev.pok), .arp_opcode(cur_ev.op),
    .arp_sender_ip(cur_ev.sip), .arp_sender_mac(cur_ev.smac),
    .arp_tpa(cur_ev.tip), .elapsed_ms(cur_ev.elapsed),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .dest_mac(dest_mac), .out_ip(out_ip), .out_tag(out_tag), .last(last)
  );

  // Model of the block's registers and tables.
  logic [47:0] cfg_mac;
  logic [31:0] cfg_ip;
  logic [16:0] cfg_holdoff;
  logic [16:0] cfg_lifetime;
  logic [31:0] cache_ip    [N_CACHE];
  logic [47:0] cache_mac   [N_CACHE];
  logic [16:0] cache_age   [N_CACHE];
  logic        cache_valid [N_CACHE];
  logic [31:0] arq_ip      [N_REQ];
  logic [16:0] arq_age     [N_REQ];
  logic        arq_valid   [N_REQ];
  logic [15:0] wait_tag    [N_PEND];
  logic [31:0] wait_ip     [N_PEND];
  int          wait_count;

  arp_event_t  event_q[$];
  arp_result_t expected_q[$];
  arp_result_t step_res[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_events = 0, n_results = 0, n_errors = 0, idle_cycles = 0;
  logic [31:0] ip_pool [20];

  initial begin
    cur_ev = '{default: '0};
  end

  function automatic logic [16:0] sat_age(logic [16:0] a, logic [15:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 131071) ? 17'h1FFFF : s[16:0];
  endfunction

  function automatic int cache_lookup(logic [31:0] ip);
    for (int i = 0; i < N_CACHE; i++)
      if (cache_valid[i] && cache_ip[i] == ip) return i;
    return -1;
  endfunction

  task automatic queue_event(arp_event_t ev);
    event_q = {event_q, ev};
  endtask

  task automatic note_result(logic [2:0] kind, logic [47:0] mac, logic [31:0] ip,
                             logic [15:0] tag);
    arp_result_t r;
    r = '{kind, mac, ip, tag, 1'b0};
    step_res = {step_res, r};
  endtask

  // Enters or refreshes a mapping; when the cache is full the oldest entry goes.
  task automatic learn_mapping(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = cache_lookup(ip);
    if (slot < 0)
      for (int i = 0; i < N_CACHE && slot < 0; i++)
        if (!cache_valid[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < N_CACHE; i++)
        if (cache_age[i] > cache_age[slot]) slot = i;
    end
    cache_ip[slot] = ip;
    cache_mac[slot] = mac;
    cache_age[slot] = '0;
    cache_valid[slot] = 1'b1;
    for (int i = 0; i < N_REQ; i++)
      if (arq_valid[i] && arq_ip[i] == ip) arq_valid[i] = 1'b0;
  endtask

  task automatic model_send(logic [31:0] ip, logic [15:0] tag);
    int slot, rq;
    logic bc;
    slot = cache_lookup(ip);
    rq = -1;
    if (slot >= 0) begin
      note_result(KIND_FRAME, cache_mac[slot], ip, tag);
      return;
    end
    for (int i = 0; i < N_REQ && rq < 0; i++)
      if (arq_valid[i] && arq_ip[i] == ip) rq = i;
    if (rq >= 0) begin
      // A repeat request goes out only once the holdoff has passed.
      bc = arq_age[rq] > cfg_holdoff;
      if (bc) arq_age[rq] = '0;
    end else begin
      for (int i = 0; i < N_REQ && rq < 0; i++)
        if (!arq_valid[i]) rq = i;
      if (rq < 0) begin
        rq = 0;
        for (int i = 1; i < N_REQ; i++)
          if (arq_age[i] > arq_age[rq]) rq = i;
      end
      arq_ip[rq] = ip;
      arq_age[rq] = '0;
      arq_valid[rq] = 1'b1;
      bc = 1'b1;
    end
    if (wait_count < N_PEND) begin
      wait_tag[wait_count] = tag;
      wait_ip[wait_count] = ip;
      wait_count++;
    end else begin
      note_result(KIND_DROP, '0, ip, tag);
    end
    if (bc) note_result(KIND_REQUEST, BCAST_MAC, ip, '0);
  endtask

  // Works out the results of one accepted request and queues them.
  task automatic predict_event(arp_event_t ev);
    int w, s;
    step_res.delete();
    case (ev.func)
      FUNC_SEND: model_send(ev.hop, ev.tag);
      FUNC_RECV: begin
        if (ev.dst == cfg_mac || ev.dst == BCAST_MAC) begin
          if (ev.ftype == ETYPE_IPV4 && ev.pok) begin
            note_result(KIND_DELIVER, '0, '0, ev.tag);
          end else if (ev.ftype == ETYPE_ARP && ev.pok) begin
            if (ev.op == ARP_OP_REPLY) begin
              learn_mapping(ev.sip, ev.smac);
            end else if (ev.op == ARP_OP_REQUEST) begin
              learn_mapping(ev.sip, ev.smac);
              if (ev.tip == cfg_ip) note_result(KIND_REPLY, ev.smac, ev.sip, '0);
            end
            w = 0;
            for (int k = 0; k < wait_count; k++) begin
              s = cache_lookup(wait_ip[k]);
              if (s >= 0) begin
                note_result(KIND_FRAME, cache_mac[s], wait_ip[k], wait_tag[k]);
              end else begin
                wait_tag[w] = wait_tag[k];
                wait_ip[w] = wait_ip[k];
                w++;
              end
            end
            wait_count = w;
          end
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < N_REQ; i++)
          if (arq_valid[i]) arq_age[i] = sat_age(arq_age[i], ev.elapsed);
        for (int i = 0; i < N_CACHE; i++)
          if (cache_valid[i]) begin
            cache_age[i] = sat_age(cache_age[i], ev.elapsed);
            if (cache_age[i] > cfg_lifetime) cache_valid[i] = 1'b0;
          end
      end
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size()-1].fin = 1'b1;
    expected_q = {expected_q, step_res};
  endtask

  // Driver: a new request is offered at the falling edge once the last one
  // has been taken, or held steady while the block stalls it.
  logic in_taken = 1'b0;
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!rst && (!in_valid || in_taken)) begin
      if (event_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_ev <= event_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: accepted requests feed the model, accepted results are checked.
  always @(posedge clk) begin
    arp_result_t e;
    in_taken = in_valid && !in_stall && !rst;
    if (in_taken) begin
      predict_event(cur_ev);
      n_events++;
    end
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected result kind %0d mac %h ip %h tag %h last %b",
                   out_kind, dest_mac, out_ip, out_tag, last);
      end else begin
        e = expected_q.pop_front();
        if (out_kind !== e.kind || dest_mac !== e.mac || out_ip !== e.ip ||
            out_tag !== e.tag || last !== e.fin) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d expected %0d/%h/%h/%h/%b got %0d/%h/%h/%h/%b",
                     n_results, e.kind, e.mac, e.ip, e.tag, e.fin,
                     out_kind, dest_mac, out_ip, out_tag, last);
        end
      end
    end
  end

  // Watchdog on stretches with no traffic on either channel.
  always @(posedge clk) begin
    if (in_taken || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out with %0d results outstanding.", expected_q.size());
      $display("FAIL arp_resolver_with_pending_queue");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_OWN_MAC:  cfg_mac = value[47:0];
      REG_OWN_IP:   cfg_ip = value[31:0];
      REG_HOLDOFF:  cfg_holdoff = value[16:0];
      default:      cfg_lifetime = value[16:0];
    endcase
  endtask

  // Waits until every request is in and every result out, then lets the
  // block finish any event that gives no result.
  task automatic drain();
    while (event_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic arp_event_t blank_event(logic [1:0] f);
    arp_event_t ev;
    ev = '{default: '0};
    ev.func = f;
    ev.pok = 1'b1;
    return ev;
  endfunction

  function automatic arp_event_t send_ev(logic [31:0] ip, logic [15:0] tag);
    arp_event_t ev;
    ev = blank_event(FUNC_SEND);
    ev.hop = ip;
    ev.tag = tag;
    return ev;
  endfunction

  function automatic arp_event_t arp_ev(logic [15:0] op, logic [31:0] sip,
                                        logic [47:0] smac, logic [31:0] tip);
    arp_event_t ev;
    ev = blank_event(FUNC_RECV);
    ev.dst = $urandom_range(0, 1) ? BCAST_MAC : cfg_mac;
    ev.ftype = ETYPE_ARP;
    ev.op = op; ev.sip = sip; ev.smac = smac; ev.tip = tip;
    return ev;
  endfunction

  function automatic arp_event_t tick_ev(logic [15:0] ms);
    arp_event_t ev;
    ev = blank_event(FUNC_TICK);
    ev.elapsed = ms;
    return ev;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Random request: mostly traffic around a small set of neighbours so the
  // cache, the request table and the queue all fill up and turn over.
  function automatic arp_event_t random_event();
    arp_event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      ev = send_ev(ip_pool[$urandom_range(0, 19)], 16'($urandom()));
    end else if (pick < 60) begin
      ev = arp_ev($urandom_range(0, 3) == 0 ? ARP_OP_REQUEST : ARP_OP_REPLY,
                  ip_pool[$urandom_range(0, 19)], rand48(),
                  $urandom_range(0, 1) ? cfg_ip : $urandom());
      if ($urandom_range(0, 9) == 0) ev.op = 16'($urandom());
    end else if (pick < 75) begin
      ev = tick_ev($urandom_range(0, 3) == 0 ? 16'($urandom()) :
                   16'($urandom_range(0, 3000)));
    end else if (pick < 83) begin
      ev = blank_event(FUNC_RECV);
      ev.dst = $urandom_range(0, 1) ? BCAST_MAC : cfg_mac;
      ev.ftype = ETYPE_IPV4;
      ev.tag = 16'($urandom());
    end else begin
      // Noise: every field at full width, often with a recognisable type.
      ev.func = 2'($urandom()); ev.hop = $urandom(); ev.tag = 16'($urandom());
      ev.dst = $urandom_range(0, 1) ? rand48() : cfg_mac;
      ev.ftype = $urandom_range(0, 1) ? ETYPE_ARP : 16'($urandom());
      ev.pok = 1'($urandom()); ev.op = 16'($urandom()); ev.sip = $urandom();
      ev.smac = rand48(); ev.tip = $urandom(); ev.elapsed = 16'($urandom());
    end
    return ev;
  endfunction

  initial begin
    arp_event_t ev;
    logic [63:0] cfg_sets [5][4];
    cfg_mac = '0; cfg_ip = '0;
    cfg_holdoff = HOLDOFF_RESET; cfg_lifetime = LIFETIME_RESET;
    for (int i = 0; i < N_CACHE; i++) begin
      cache_ip[i] = '0; cache_mac[i] = '0; cache_age[i] = '0; cache_valid[i] = 1'b0;
    end
    for (int i = 0; i < N_REQ; i++) begin
      arq_ip[i] = '0; arq_age[i] = '0; arq_valid[i] = 1'b0;
    end
    wait_count = 0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    // Register settings per phase, extremes among them.
    cfg_sets[0] = '{64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF, 64'd0, 64'd0};
    cfg_sets[1] = '{64'h0, 64'h0, 64'd100000, 64'd100000};
    cfg_sets[2] = '{64'(rand48()), 64'($urandom()), 64'd1000, 64'd4000};
    cfg_sets[3] = '{64'(rand48()), 64'($urandom()), 64'd200, 64'd100000};
    cfg_sets[4] = '{64'(rand48()), 64'(ip_pool[2]), 64'd3000, 64'd8000};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under the reset register values.
    queue_event(send_ev(32'h0A00_0001, 16'h0000));                  // miss, request
    queue_event(send_ev(32'h0A00_0001, 16'hFFFF));                  // held off, silent
    queue_event(arp_ev(ARP_OP_REPLY, 32'h0A00_0001, 48'h0000_0000_0001,
                       32'h0));                                     // flushes queue
    queue_event(send_ev(32'h0A00_0001, 16'h1234));                  // cache hit
    queue_event(arp_ev(ARP_OP_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFE,
                       cfg_ip));                                    // answered
    queue_event(arp_ev(16'hFFFF, 32'h0A00_0002, 48'h1, 32'h0));     // other opcode
    ev = arp_ev(ARP_OP_REPLY, 32'h0A00_0003, 48'h2, 32'h0);
    ev.pok = 1'b0;
    queue_event(ev);                                                // bad parse
    ev = arp_ev(ARP_OP_REPLY, 32'h0A00_0003, 48'h2, 32'h0);
    ev.dst = 48'h1234_5678_9ABC;
    queue_event(ev);                                                // not for us
    ev = blank_event(FUNC_RECV);
    ev.dst = BCAST_MAC; ev.ftype = ETYPE_IPV4; ev.tag = 16'hA5A5;
    queue_event(ev);                                                // delivered
    ev = blank_event(2'd3);
    ev.hop = '1;
    queue_event(ev);                                                // unknown kind
    queue_event(tick_ev(16'hFFFF));                                 // evicts all
    queue_event(tick_ev(16'hFFFF));                                 // nothing left to age
    queue_event(send_ev(32'h0A00_0001, 16'h0001));                  // request again
    for (int i = 0; i < 6; i++)                                     // queues six more
      queue_event(send_ev(32'(32'h0B00_0000 + i), 16'(16'h0100 + i)));
    for (int i = 0; i < 11; i++)                                    // fills the queue, then drops
      queue_event(send_ev(32'(32'h0C00_0000 + i), 16'(16'h0200 + i)));
    queue_event(arp_ev(ARP_OP_REPLY, 32'h0B00_0000, 48'hBEEF, 32'h0));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph > 0) begin
        drain();
        for (int r = 0; r < 4; r++) reg_write(r[1:0], cfg_sets[ph-1][r]);
      end
      for (int i = 0; i < 50; i++) queue_event(random_event());
    end

    drain();
    $display("Covered %0d requests and %0d results over six phases of register", n_events,
             n_results);
    $display("settings and sender/receiver idling; %0d mismatches.", n_errors);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("PASS arp_resolver_with_pending_queue");
    end else begin
      $display("FAIL arp_resolver_with_pending_queue");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/arp_pkg.sv
hw/rtl/arp_ram.sv
hw/rtl/arp_resolver_with_pending_queue.sv
tb/tb.sv
